@@ rtl/gtg_pkg.sv @@
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Word types, register indexes, fixed-point constants and the arctangent table
// shared by the go-to-goal proportional controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Number of CORDIC micro-rotations and the length of the arctangent table.
  localparam int CordicIters = 16;
  localparam int AtanLen = 24;
  localparam int CordicStages = (CordicIters < AtanLen) ? CordicIters : AtanLen;

  // Pipeline layout: one pre-rotation stage, one stage per micro-rotation,
  // then distance scaling, rounding and gating, gain products and output.
  localparam int StDist = CordicStages + 1;
  localparam int StRound = CordicStages + 2;
  localparam int StProd = CordicStages + 3;
  localparam int StOut = CordicStages + 4;
  localparam int NumStages = CordicStages + 5;

  // Datapath widths.
  localparam int CoordW = 12;
  localparam int HeadW = 16;
  localparam int OutW = 16;
  localparam int ShiftIn = 14;
  localparam int XW = 30;       // CORDIC x and y, magnitude stays below 2^28
  localparam int ZW = 28;       // accumulated angle, Q24 radians
  localparam int ErrW = 27;     // wrapped heading error, Q24 within plus/minus pi
  localparam int DistW = 14;    // distance, Q6.8
  localparam int DProdW = 44;   // x times 1/K
  localparam int LinProdW = CoordW + DistW;
  localparam int AngProdW = CoordW + 1 + ErrW;

  // Fixed-point constants.
  localparam int InvKQ16 = 39797;
  localparam int PiQ24 = 52707179;
  localparam int TwoPiQ24 = 105414358;
  localparam int HalfPiQ24 = 26353589;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgTargetX      = 3'd0,
    CfgTargetY      = 3'd1,
    CfgGainLinear   = 3'd2,
    CfgGainAngular  = 3'd3,
    CfgStopDistance = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0]       pose_x;
    logic [CoordW-1:0]       pose_y;
    logic signed [HeadW-1:0] pose_heading;
  } pose_t;

  typedef struct packed {
    logic [OutW-1:0]        linear_speed;
    logic signed [OutW-1:0] angular_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic signed [HeadW-1:0] hd;
  } cordic_t;

  // atan(2^-i) in Q24 radians, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:  val = ZW'(13176795);
      1:  val = ZW'(7778716);
      2:  val = ZW'(4110060);
      3:  val = ZW'(2086331);
      4:  val = ZW'(1047214);
      5:  val = ZW'(524117);
      6:  val = ZW'(262123);
      7:  val = ZW'(131069);
      8:  val = ZW'(65536);
      9:  val = ZW'(32768);
      10: val = ZW'(16384);
      11: val = ZW'(8192);
      12: val = ZW'(4096);
      13: val = ZW'(2048);
      14: val = ZW'(1024);
      15: val = ZW'(512);
      16: val = ZW'(256);
      17: val = ZW'(128);
      18: val = ZW'(64);
      19: val = ZW'(32);
      20: val = ZW'(16);
      21: val = ZW'(8);
      22: val = ZW'(4);
      23: val = ZW'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/go_to_goal_p_controller_top.sv @@
// ----------------------------------------------------------------------------
// Go-to-goal proportional controller
// Turns a pose word into linear speed and turn rate commands toward a target.
// ----------------------------------------------------------------------------
// The block takes pose words and returns one command word per pose, in order,
// through a pipeline: one stage forms the offset to the target and folds it
// into the right half plane, one stage per vectoring CORDIC micro-rotation
// follows, then the distance is scaled by 1/K and the heading error is
// wrapped into (-pi, pi], the distance is rounded and compared with the stop
// threshold, both gains are applied, and the last stage rounds, saturates and
// registers the command. The sustained rate is one word per cycle while the
// output is taken, set by the fully unrolled CORDIC pipeline. Each stage
// moves forward whenever the stage after it is empty or moving, so a stalled
// output only holds back words that have nowhere to go, and empty slots in the
// pipeline still take new poses. Distances at or below stop_distance give zero
// on both outputs. The configuration registers are read directly by the
// pipeline and must be written only while no pose word is in flight; the
// configuration channel is always ready and ignores indexes beyond the list.
module go_to_goal_p_controller_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gtg_pkg::pose_t         in_data_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gtg_pkg::cmd_t          out_data_o,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [gtg_pkg::CoordW-1:0] cfg_data_i
);
  import gtg_pkg::*;

  // Configuration registers.
  logic [CoordW-1:0] target_x_q, target_y_q, gain_linear_q, gain_angular_q, stop_distance_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q      <= CoordW'(2304);
      target_y_q      <= CoordW'(2304);
      gain_linear_q   <= CoordW'(256);
      gain_angular_q  <= CoordW'(1024);
      stop_distance_q <= CoordW'(26);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgTargetX:      target_x_q      <= cfg_data_i;
        CfgTargetY:      target_y_q      <= cfg_data_i;
        CfgGainLinear:   gain_linear_q   <= cfg_data_i;
        CfgGainAngular:  gain_angular_q  <= cfg_data_i;
        CfgStopDistance: stop_distance_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage advance enables. A stage advances when the
  // output is being taken or any stage from it to the output is empty.
  logic [NumStages-1:0] valid_q, valid_d, adv;

  always_comb begin
    logic [NumStages-1:0] low_mask;
    for (int k = 0; k < NumStages; k++) begin
      low_mask = NumStages'((64'd1 << k) - 64'd1);
      adv[k] = out_ready_i || !(&(valid_q | low_mask));
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[StOut];

  // Stage 0: offset to the target, scaled up, and folded into x >= 0.
  cordic_t cordic_q [CordicStages+1];
  cordic_t pre_d;

  always_comb begin
    logic signed [CoordW:0] dx, dy;
    logic signed [XW-1:0]   x0, y0;
    dx = signed'({1'b0, target_x_q}) - signed'({1'b0, in_data_i.pose_x});
    dy = signed'({1'b0, target_y_q}) - signed'({1'b0, in_data_i.pose_y});
    x0 = {{(XW-CoordW-1-ShiftIn){dx[CoordW]}}, dx, {ShiftIn{1'b0}}};
    y0 = {{(XW-CoordW-1-ShiftIn){dy[CoordW]}}, dy, {ShiftIn{1'b0}}};
    pre_d.hd = in_data_i.pose_heading;
    if (x0[XW-1]) begin
      if (!y0[XW-1]) begin
        pre_d.x = y0;
        pre_d.y = -x0;
        pre_d.z = ZW'(HalfPiQ24);
      end else begin
        pre_d.x = -y0;
        pre_d.y = x0;
        pre_d.z = ZW'(-HalfPiQ24);
      end
    end else begin
      pre_d.x = x0;
      pre_d.y = y0;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cordic_q[0] <= pre_d;
    end
  end

  // One vectoring micro-rotation per stage, driving y toward zero.
  for (genvar gi = 1; gi <= CordicStages; gi++) begin : g_cordic
    cordic_t rot_d;

    always_comb begin
      logic signed [XW-1:0] cx, cy, xs, ys;
      logic signed [ZW-1:0] cz;
      cx = cordic_q[gi-1].x;
      cy = cordic_q[gi-1].y;
      cz = cordic_q[gi-1].z;
      xs = cx >>> (gi - 1);
      ys = cy >>> (gi - 1);
      rot_d.hd = cordic_q[gi-1].hd;
      if (cy[XW-1]) begin
        rot_d.x = cx - ys;
        rot_d.y = cy + xs;
        rot_d.z = cz - atan_q24(gi - 1);
      end else begin
        rot_d.x = cx + ys;
        rot_d.y = cy - xs;
        rot_d.z = cz + atan_q24(gi - 1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[gi]) begin
        cordic_q[gi] <= rot_d;
      end
    end
  end

  // Distance scaling by 1/K, and the heading error wrapped into (-pi, pi].
  logic [DProdW-1:0]      dprod_q, dprod_d;
  logic signed [ErrW-1:0] err_q, err_d, err2_q;

  always_comb begin
    logic signed [ZW:0] err_raw;
    logic signed [ZW:0] hd_q24;
    hd_q24 = {{2{cordic_q[CordicStages].hd[HeadW-1]}}, cordic_q[CordicStages].hd, 11'b0};
    dprod_d = cordic_q[CordicStages].x[ZW-1:0] * 16'(InvKQ16);
    err_raw = {cordic_q[CordicStages].z[ZW-1], cordic_q[CordicStages].z} - hd_q24;
    if (err_raw > PiQ24) begin
      err_d = ErrW'(err_raw - TwoPiQ24);
    end else if (err_raw <= -PiQ24) begin
      err_d = ErrW'(err_raw + TwoPiQ24);
    end else begin
      err_d = err_raw[ErrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StDist]) begin
      dprod_q <= dprod_d;
      err_q   <= err_d;
    end
  end

  // Rounded distance in Q6.8 and the stop test.
  logic [DistW-1:0] dist_q;
  logic             move_q, move2_q, move3_q;
  logic [DProdW-1:0] dist_sum;

  assign dist_sum = dprod_q + DProdW'(64'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (adv[StRound]) begin
      dist_q  <= dist_sum[DProdW-1:30];
      move_q  <= dist_sum[DProdW-1:30] > {{(DistW-CoordW){1'b0}}, stop_distance_q};
      err2_q  <= err_q;
    end
  end

  // Gain products.
  logic [LinProdW-1:0]        lin_prod_q;
  logic signed [AngProdW-1:0] ang_prod_q;
  logic signed [CoordW:0]     gain_ang_s;

  assign gain_ang_s = signed'({1'b0, gain_angular_q});

  always_ff @(posedge clk_i) begin
    if (adv[StProd]) begin
      lin_prod_q <= gain_linear_q * dist_q;
      ang_prod_q <= gain_ang_s * err2_q;
      move2_q    <= move_q;
    end
  end

  // Round, saturate and gate into the output register.
  cmd_t out_q, out_d;

  always_comb begin
    logic [LinProdW:0]        lin_sum;
    logic [LinProdW-8:0]      lin_sh;
    logic signed [AngProdW:0] ang_sum;
    logic signed [AngProdW-24:0] ang_sh;
    lin_sum = {1'b0, lin_prod_q} + (LinProdW+1)'(128);
    lin_sh  = lin_sum[LinProdW:8];
    ang_sum = {ang_prod_q[AngProdW-1], ang_prod_q} + (AngProdW+1)'(64'd1 << 23);
    ang_sh  = ang_sum[AngProdW:24];
    if (!move2_q) begin
      out_d.linear_speed = '0;
      out_d.angular_rate = '0;
    end else begin
      if (|lin_sh[LinProdW-8:OutW]) begin
        out_d.linear_speed = '1;
      end else begin
        out_d.linear_speed = lin_sh[OutW-1:0];
      end
      if (ang_sh[AngProdW-24] == ang_sh[OutW-1] &&
          (&ang_sh[AngProdW-24:OutW-1] || !(|ang_sh[AngProdW-24:OutW-1]))) begin
        out_d.angular_rate = ang_sh[OutW-1:0];
      end else if (ang_sh[AngProdW-24]) begin
        out_d.angular_rate = {1'b1, {(OutW-1){1'b0}}};
      end else begin
        out_d.angular_rate = {1'b0, {(OutW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StOut]) begin
      out_q   <= out_d;
      move3_q <= move2_q;
    end
  end

  assign out_data_o = out_q;

  // A word that was gated off by the stop test carries a zero command.
  // Checks on the pipeline's own invariants.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while the output register is empty");

  a_prerot_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> !cordic_q[0].x[XW-1])
    else $error("pre-rotation left a negative x");

  a_cordic_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[CordicStages] |-> (cordic_q[CordicStages].x[XW-1:ZW] == '0))
    else $error("CORDIC magnitude outside the scaling multiplier's range");

  a_err_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StDist] |-> (err_q <= PiQ24 && err_q > -PiQ24))
    else $error("heading error not wrapped into (-pi, pi]");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !move3_q) |-> (out_q.linear_speed == '0 && out_q.angular_rate == '0))
    else $error("stopped word carries a nonzero command");

endmodule

@@ tb/sv/gtg_command_checker.sv @@
// ----------------------------------------------------------------------------
// Go-to-goal command checker
// Watches the pose, command and register channels of the go-to-goal
// controller, predicts each command word from the accepted pose word and the
// register values seen so far, and compares the commands in order.
// ----------------------------------------------------------------------------
module gtg_command_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  gtg_pkg::pose_t              in_data_i,

  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  gtg_pkg::cmd_t               out_data_i,

  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [gtg_pkg::CoordW-1:0]  cfg_data_i,

  output int                          fail_count_o,
  output int                          cmds_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  localparam int     AtanSteps  = 24;
  localparam int     PoseShift  = 14;
  localparam longint InvGainQ16 = 39797;
  localparam longint PiRad      = 52707179;
  localparam longint TwoPiRad   = 105414358;
  localparam longint HalfPiRad  = 26353589;

  // Register copies, as the block holds them.
  logic [CoordW-1:0] goal_x, goal_y, lin_gain, turn_gain, stop_dist;

  longint atan_step [AtanSteps];
  cmd_t   cmd_q [$];
  int     fails;

  initial begin
    atan_step = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                  131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2};
  end

  // Distance and bearing by vectoring micro-rotations, then the two gains.
  function automatic cmd_t predict_command(input pose_t p);
    longint x, y, z, t, xs, ys, distance, err, lin, ang, hd;
    cmd_t   c;
    hd = longint'(signed'(p.pose_heading));
    x  = (longint'(goal_x) - longint'(p.pose_x)) * (64'sd1 <<< PoseShift);
    y  = (longint'(goal_y) - longint'(p.pose_y)) * (64'sd1 <<< PoseShift);
    z  = 0;
    // Fold a left-half-plane offset into the right half plane.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HalfPiRad;
      end else begin
        x = -y;
        y = t;
        z = -HalfPiRad;
      end
    end
    for (int i = 0; i < CordicIters && i < AtanSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end
    end
    distance = (x * InvGainQ16 + (64'sd1 <<< 29)) >>> 30;
    err  = z - hd * 2048;
    if (err > PiRad) begin
      err = err - TwoPiRad;
    end else if (err <= -PiRad) begin
      err = err + TwoPiRad;
    end
    if (distance > longint'(stop_dist)) begin
      lin = (longint'(lin_gain) * distance + 128) >>> 8;
      if (lin > 65535) lin = 65535;
      ang = (longint'(turn_gain) * err + (64'sd1 <<< 23)) >>> 24;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
    end else begin
      lin = 0;
      ang = 0;
    end
    c.linear_speed = lin[OutW-1:0];
    c.angular_rate = ang[OutW-1:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t got, want;
    if (!rst_ni) begin
      goal_x    = 12'd2304;
      goal_y    = 12'd2304;
      lin_gain  = 12'd256;
      turn_gain = 12'd1024;
      stop_dist = 12'd26;
      cmd_q.delete();
      fails = 0;
      fail_count_o   <= 0;
      cmds_pending_o <= 0;
    end else begin
      // The command leaving now always belongs to an older pose than the one
      // entering now, so it is compared first.
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (cmd_q.size() == 0) begin
          $display("%0t: command word with none expected: linear %0d angular %0d",
                   $time, got.linear_speed, got.angular_rate);
          fails++;
        end else begin
          want = cmd_q.pop_front();
          if (got.linear_speed !== want.linear_speed) begin
            $display("%0t: linear_speed expected %0d, got %0d",
                     $time, want.linear_speed, got.linear_speed);
            fails++;
          end
          if (got.angular_rate !== want.angular_rate) begin
            $display("%0t: angular_rate expected %0d, got %0d",
                     $time, want.angular_rate, got.angular_rate);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        cmd_q.push_back(predict_command(in_data_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTargetX:      goal_x    = cfg_data_i;
          CfgTargetY:      goal_y    = cfg_data_i;
          CfgGainLinear:   lin_gain  = cfg_data_i;
          CfgGainAngular:  turn_gain = cfg_data_i;
          CfgStopDistance: stop_dist = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o   <= fails;
      cmds_pending_o <= cmd_q.size();
    end
  end

endmodule

@@ tb/sv/tb_go_to_goal_p_controller_top.sv @@
// ----------------------------------------------------------------------------
// Go-to-goal controller testbench
// Drives pose words and register writes into the controller with random
// stalls on both sides, while a checker beside it predicts every command
// word and compares it with what comes out.
// ----------------------------------------------------------------------------
module tb_go_to_goal_p_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  // Longest single gap on either side, in cycles.
  localparam int MaxGap = 18;
  // Length of the long receiver hold-off that backs the pipeline up.
  localparam int HoldCycles = 300;
  // Cycles without any accepted word before the run is declared hung.
  localparam int StallLimit = 4000;
  // Quiet time after the last command, enough for a stray extra word to show.
  localparam int SettleCycles = NumStages + 8;
  // An index past the register list; the block must ignore writes to it.
  localparam logic [2:0] CfgIndexSpare = 3'd7;
  localparam int RandomPhases = 5;
  localparam int PhaseWords = 70;
  localparam int TailWords = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  pose_t             in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  cmd_t              out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [CoordW-1:0] cfg_data_i;

  int fail_count;
  int cmds_pending;

  // Shared knobs between the sender and the receiver. idle_on enables random
  // gaps on both sides; hold_req asks the receiver for one long hold-off.
  bit idle_on;
  bit hold_req;

  // The sender's view of the target and threshold, used to aim poses at the
  // interesting region around the goal.
  logic [CoordW-1:0] cur_tx, cur_ty, cur_stop;

  go_to_goal_p_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  gtg_command_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .cmds_pending_o (cmds_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset is applied once and released on a clock edge.
  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Clamps an offset position into the 12-bit coordinate range.
  function automatic logic [CoordW-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[CoordW-1:0];
  endfunction

  // A register value biased toward the ends of its range.
  function automatic logic [CoordW-1:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 12'd4095;
      default: return CoordW'($urandom_range(0, 4095));
    endcase
  endfunction

  // Random pose word. Part of the words land close to the goal, on or off an
  // axis, so the distance often falls near the stop threshold; the rest are
  // spread over the whole field. Headings are mostly within plus or minus pi,
  // and sometimes anywhere in the 16-bit range so that the wrap is exercised.
  function automatic pose_t random_pose();
    pose_t p;
    int    r;
    r = int'(cur_stop) + 8;
    case ($urandom_range(0, 3))
      0: begin
        p.pose_x = clamp_coord(int'(cur_tx) + int'($urandom_range(0, 2 * r)) - r);
        p.pose_y = cur_ty;
      end
      1: begin
        p.pose_x = clamp_coord(int'(cur_tx) + int'($urandom_range(0, 2 * r)) - r);
        p.pose_y = clamp_coord(int'(cur_ty) + int'($urandom_range(0, 2 * r)) - r);
      end
      default: begin
        p.pose_x = CoordW'($urandom_range(0, 4095));
        p.pose_y = CoordW'($urandom_range(0, 4095));
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      p.pose_heading = HeadW'($urandom_range(0, 65535));
    end else begin
      p.pose_heading = HeadW'(int'($urandom_range(0, 51472)) - 25736);
    end
    return p;
  endfunction

  // Offers one pose word and returns once it has been taken. Valid stays high
  // afterwards so the next word can follow back to back; a random gap lowers
  // it first.
  task automatic send_pose(input pose_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_at(input int x, input int y, input int h);
    pose_t p;
    p.pose_x       = CoordW'(x);
    p.pose_y       = CoordW'(y);
    p.pose_heading = HeadW'(h);
    send_pose(p);
  endtask

  // One register write; valid is left high for the next write.
  task automatic write_reg(input logic [2:0] idx, input logic [CoordW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes every register, sometimes with a stray write to an unused index
  // mixed in, and then drops the write valid.
  task automatic apply_config(input logic [CoordW-1:0] tx, input logic [CoordW-1:0] ty,
                              input logic [CoordW-1:0] gl, input logic [CoordW-1:0] ga,
                              input logic [CoordW-1:0] sd);
    write_reg(CfgTargetX, tx);
    write_reg(CfgTargetY, ty);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgIndexSpare, CoordW'($urandom_range(0, 4095)));
    end
    write_reg(CfgGainLinear, gl);
    write_reg(CfgGainAngular, ga);
    write_reg(CfgStopDistance, sd);
    cfg_valid_i <= 1'b0;
    cur_tx   = tx;
    cur_ty   = ty;
    cur_stop = sd;
  endtask

  // The sender stops and waits until every expected command has come back.
  // The first edge lets the checker count the last pose that went in.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmds_pending != 0) @(posedge clk_i);
  endtask

  // Receiver: alternates ready bursts with random stall bursts while idling is
  // on, and serves one long hold-off when the sender asks for it.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any cycle in which a word moves on some channel restarts it.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    cur_tx   = 12'd2304;
    cur_ty   = 12'd2304;
    cur_stop = 12'd26;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Reset values of the registers: goal at (9, 9), threshold about 0.1.
    send_at(2304, 2304, 0);           // at the goal
    send_at(2278, 2304, 0);           // distance equal to the threshold
    send_at(2277, 2304, 0);           // just beyond the threshold
    send_at(2279, 2304, 0);           // just inside the threshold
    send_at(2304, 2278, 0);
    send_at(2305, 2304, -25736);      // tiny step behind the goal
    send_at(0, 0, 0);
    send_at(4095, 4095, 0);           // offset in the third quadrant
    send_at(4095, 0, 0);              // offset in the second quadrant
    send_at(2400, 2304, 0);           // straight behind, dy of zero
    send_at(0, 4095, 25736);
    send_at(0, 0, -25736);
    send_at(4095, 2304, 32767);       // heading well beyond pi
    send_at(4095, 2305, -32768);
    send_at(2304, 0, 32767);
    send_at(2304, 4095, -32768);
    send_at(1000, 3000, 12345);
    drain();

    // Goal at the origin, largest gains, no threshold: speed saturates.
    apply_config(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0);
    send_at(0, 0, 0);
    send_at(1, 0, 0);
    send_at(4095, 4095, 25736);
    send_at(4095, 0, -25736);
    send_at(0, 4095, 32767);
    drain();

    // Far goal, zero gains, largest threshold.
    apply_config(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4095);
    send_at(0, 0, 0);
    send_at(4095, 4095, 0);
    send_at(0, 4095, -32768);
    drain();

    // Random phases, each under its own register setting. One phase runs
    // without any idling on either side.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      apply_config(pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                   ($urandom_range(0, 1) == 0) ? CoordW'($urandom_range(0, 64)) : pick_reg());
      idle_on = (ph != 2);
      for (int n = 0; n < PhaseWords; n++) begin
        send_pose(random_pose());
      end
      drain();
    end

    // Back-pressure: the receiver holds off for a long stretch while poses
    // keep coming, so the pipeline fills and the input stalls.
    apply_config(12'd2304, 12'd1280, 12'd512, 12'd2048, 12'd26);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < PhaseWords; n++) begin
      send_pose(random_pose());
    end
    drain();

    // Final stretch with no idling at all.
    apply_config(CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)),
                 CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)),
                 CoordW'($urandom_range(0, 128)));
    for (int n = 0; n < TailWords; n++) begin
      send_pose(random_pose());
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0 && cmds_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
